@@ design/rso_pkg.sv @@
`timescale 1ns / 1ps

package rso_pkg;

    localparam int COORD_BITS    = 16;
    localparam int EDGE_BITS     = COORD_BITS + 1;
    localparam int SIZE_BITS     = COORD_BITS + 2;
    localparam int IN_DATA_BITS  = 8 * COORD_BITS;
    localparam int OUT_RECT_BITS = 2 * EDGE_BITS + 2 * SIZE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RECT_BITS + 7) / 8) * 8;

    // job queue between front and back; depth must stay a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_INTERSECT  = 2'd0,
        CMD_UNION      = 2'd1,
        CMD_DIFFERENCE = 2'd2,
        CMD_MERGE      = 2'd3
    } cmd_t;

    // result pieces of one job, emitted from the lowest bit up
    localparam int PIECE_WHOLE  = 0;
    localparam int PIECE_RIGHT  = 1;
    localparam int PIECE_LEFT   = 2;
    localparam int PIECE_BOTTOM = 3;
    localparam int PIECE_TOP    = 4;
    localparam int PIECE_COUNT  = 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EDGE_BITS-1:0]  edge_t;
    typedef logic signed [SIZE_BITS-1:0]  size_t;
    typedef logic [PIECE_COUNT-1:0]       piece_mask_t;

    // a rectangle by its edges x0, y0, x1 and y1; x1 and y1 are exclusive
    typedef struct packed {
        edge_t x0;
        edge_t y0;
        edge_t x1;
        edge_t y1;
    } box_t;

    // outer: the whole rectangle or A; inner: intersection used to cut A
    typedef struct packed {
        piece_mask_t mask;
        box_t        outer;
        box_t        inner;
    } job_t;

    function automatic box_t make_box(coord_t x, coord_t y, coord_t w, coord_t h);
        box_t b;
        b.x0 = edge_t'(x);
        b.y0 = edge_t'(y);
        b.x1 = edge_t'(x) + edge_t'(w);
        b.y1 = edge_t'(y) + edge_t'(h);
        return b;
    endfunction

endpackage

@@ design/rso_front.sv @@
`timescale 1ns / 1ps

module rso_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rso_pkg::cmd_t                       in_cmd,
    input  logic [rso_pkg::IN_DATA_BITS-1:0]    in_data,
    output logic                                job_valid,
    input  logic                                job_ready,
    output rso_pkg::job_t                       job
);

    localparam int CB = rso_pkg::COORD_BITS;

    function automatic rso_pkg::edge_t emax(rso_pkg::edge_t p, rso_pkg::edge_t q);
        return ($signed(p) > $signed(q)) ? p : q;
    endfunction

    function automatic rso_pkg::edge_t emin(rso_pkg::edge_t p, rso_pkg::edge_t q);
        return ($signed(p) < $signed(q)) ? p : q;
    endfunction

    function automatic logic covers(rso_pkg::box_t o, rso_pkg::box_t p);
        return ($signed(p.x0) >= $signed(o.x0)) && ($signed(p.x1) <= $signed(o.x1)) &&
               ($signed(p.y0) >= $signed(o.y0)) && ($signed(p.y1) <= $signed(o.y1));
    endfunction

    // stage 1: edges and emptiness
    logic            s1_valid_reg;
    rso_pkg::cmd_t   s1_cmd_reg;
    rso_pkg::box_t   s1_a_reg, s1_b_reg;
    logic            s1_a_empty_reg, s1_b_empty_reg;

    // stage 2: intersection and union
    logic            s2_valid_reg;
    rso_pkg::cmd_t   s2_cmd_reg;
    rso_pkg::box_t   s2_a_reg, s2_b_reg, s2_i_reg, s2_u_reg;
    logic            s2_a_empty_reg, s2_b_empty_reg;
    rso_pkg::box_t   s2_i_next, s2_u_next;

    // stage 3: classified job
    logic            job_valid_reg;
    rso_pkg::job_t   job_reg, job_next;

    logic en1, en2, en3;

    rso_pkg::coord_t a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h;

    assign a_x = rso_pkg::coord_t'(in_data[0*CB +: CB]);
    assign a_y = rso_pkg::coord_t'(in_data[1*CB +: CB]);
    assign a_w = rso_pkg::coord_t'(in_data[2*CB +: CB]);
    assign a_h = rso_pkg::coord_t'(in_data[3*CB +: CB]);
    assign b_x = rso_pkg::coord_t'(in_data[4*CB +: CB]);
    assign b_y = rso_pkg::coord_t'(in_data[5*CB +: CB]);
    assign b_w = rso_pkg::coord_t'(in_data[6*CB +: CB]);
    assign b_h = rso_pkg::coord_t'(in_data[7*CB +: CB]);

    assign en3      = !job_valid_reg || job_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg  <= in_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) job_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            s1_cmd_reg     <= in_cmd;
            s1_a_reg       <= rso_pkg::make_box(a_x, a_y, a_w, a_h);
            s1_b_reg       <= rso_pkg::make_box(b_x, b_y, b_w, b_h);
            s1_a_empty_reg <= (a_w <= 0) || (a_h <= 0);
            s1_b_empty_reg <= (b_w <= 0) || (b_h <= 0);
        end
        if (en2 && s1_valid_reg) begin
            s2_cmd_reg     <= s1_cmd_reg;
            s2_a_reg       <= s1_a_reg;
            s2_b_reg       <= s1_b_reg;
            s2_i_reg       <= s2_i_next;
            s2_u_reg       <= s2_u_next;
            s2_a_empty_reg <= s1_a_empty_reg;
            s2_b_empty_reg <= s1_b_empty_reg;
        end
        if (en3 && s2_valid_reg) begin
            job_reg <= job_next;
        end
    end

    always_comb begin
        s2_i_next.x0 = emax(s1_a_reg.x0, s1_b_reg.x0);
        s2_i_next.y0 = emax(s1_a_reg.y0, s1_b_reg.y0);
        s2_i_next.x1 = emin(s1_a_reg.x1, s1_b_reg.x1);
        s2_i_next.y1 = emin(s1_a_reg.y1, s1_b_reg.y1);
        if (s1_a_empty_reg) begin
            s2_u_next = s1_b_reg;
        end else if (s1_b_empty_reg) begin
            s2_u_next = s1_a_reg;
        end else begin
            s2_u_next.x0 = emin(s1_a_reg.x0, s1_b_reg.x0);
            s2_u_next.y0 = emin(s1_a_reg.y0, s1_b_reg.y0);
            s2_u_next.x1 = emax(s1_a_reg.x1, s1_b_reg.x1);
            s2_u_next.y1 = emax(s1_a_reg.y1, s1_b_reg.y1);
        end
    end

    logic          i_full, u_full;
    logic          cut_r, cut_l, cut_b, cut_t;
    logic          mrg_r, mrg_l, mrg_b, mrg_t;
    rso_pkg::box_t mrg_piece;
    logic          merge_ok;

    always_comb begin
        i_full = ($signed(s2_i_reg.x1) > $signed(s2_i_reg.x0)) &&
                 ($signed(s2_i_reg.y1) > $signed(s2_i_reg.y0));
        u_full = ($signed(s2_u_reg.x1) > $signed(s2_u_reg.x0)) &&
                 ($signed(s2_u_reg.y1) > $signed(s2_u_reg.y0));

        // pieces of A left around the intersection
        cut_r = $signed(s2_a_reg.x1) > $signed(s2_i_reg.x1);
        cut_l = $signed(s2_i_reg.x0) > $signed(s2_a_reg.x0);
        cut_b = $signed(s2_a_reg.y1) > $signed(s2_i_reg.y1);
        cut_t = $signed(s2_i_reg.y0) > $signed(s2_a_reg.y0);

        // pieces of the bounding box around A; tiling needs exactly one,
        // and B must cover it
        mrg_r = $signed(s2_u_reg.x1) > $signed(s2_a_reg.x1);
        mrg_l = $signed(s2_a_reg.x0) > $signed(s2_u_reg.x0);
        mrg_b = $signed(s2_u_reg.y1) > $signed(s2_a_reg.y1);
        mrg_t = $signed(s2_a_reg.y0) > $signed(s2_u_reg.y0);

        if (mrg_r) begin
            mrg_piece = '{x0: s2_a_reg.x1, y0: s2_a_reg.y0, x1: s2_u_reg.x1, y1: s2_a_reg.y1};
        end else if (mrg_l) begin
            mrg_piece = '{x0: s2_u_reg.x0, y0: s2_a_reg.y0, x1: s2_a_reg.x0, y1: s2_a_reg.y1};
        end else if (mrg_b) begin
            mrg_piece = '{x0: s2_u_reg.x0, y0: s2_a_reg.y1, x1: s2_u_reg.x1, y1: s2_u_reg.y1};
        end else begin
            mrg_piece = '{x0: s2_u_reg.x0, y0: s2_u_reg.y0, x1: s2_u_reg.x1, y1: s2_a_reg.y0};
        end

        merge_ok = !i_full && u_full &&
                   (s2_a_empty_reg || s2_b_empty_reg ||
                    ($onehot({mrg_r, mrg_l, mrg_b, mrg_t}) && covers(s2_b_reg, mrg_piece)));

        job_next.mask  = '0;
        job_next.outer = s2_a_reg;
        job_next.inner = s2_i_reg;
        unique case (s2_cmd_reg)
            rso_pkg::CMD_INTERSECT: begin
                job_next.outer                    = s2_i_reg;
                job_next.mask[rso_pkg::PIECE_WHOLE] = 1'b1;
            end
            rso_pkg::CMD_UNION: begin
                job_next.outer                    = s2_u_reg;
                job_next.mask[rso_pkg::PIECE_WHOLE] = 1'b1;
            end
            rso_pkg::CMD_DIFFERENCE: begin
                if (!i_full) begin
                    job_next.mask[rso_pkg::PIECE_WHOLE] = 1'b1;
                end else begin
                    job_next.mask[rso_pkg::PIECE_RIGHT]  = cut_r;
                    job_next.mask[rso_pkg::PIECE_LEFT]   = cut_l;
                    job_next.mask[rso_pkg::PIECE_BOTTOM] = cut_b;
                    job_next.mask[rso_pkg::PIECE_TOP]    = cut_t;
                end
            end
            rso_pkg::CMD_MERGE: begin
                job_next.outer                    = s2_u_reg;
                job_next.mask[rso_pkg::PIECE_WHOLE] = merge_ok;
            end
            default: begin
                job_next.mask = '0;
            end
        endcase
    end

endmodule

@@ design/rso_fifo.sv @@
`timescale 1ns / 1ps

module rso_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rso_pkg::job_t  push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rso_pkg::job_t  pop_job
);

    rso_pkg::job_t                  entry_reg [rso_pkg::QUEUE_DEPTH];
    logic [rso_pkg::QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [rso_pkg::QPTR_BITS:0]    count_reg, count_next;
    logic                           push, pop;

    assign push_ready = count_reg != (rso_pkg::QPTR_BITS + 1)'(rso_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/rso_back.sv @@
`timescale 1ns / 1ps

module rso_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                job_valid,
    output logic                                job_pop,
    input  rso_pkg::job_t                       job,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rso_pkg::OUT_DATA_BITS-1:0]   out_data,
    output logic                                out_present,
    output logic                                out_last
);

    localparam int EB = rso_pkg::EDGE_BITS;
    localparam int SB = rso_pkg::SIZE_BITS;

    rso_pkg::piece_mask_t done_reg, done_next;
    rso_pkg::piece_mask_t remain, pick;
    logic                 more, advance;

    logic                                out_valid_reg;
    logic [rso_pkg::OUT_DATA_BITS-1:0]   out_data_reg, out_data_next;
    logic                                out_present_reg;
    logic                                out_last_reg;

    rso_pkg::box_t  piece;
    rso_pkg::size_t piece_w, piece_h;

    assign remain  = job.mask & ~done_reg;
    assign pick    = remain & (~remain + 1'b1);
    assign more    = |(remain & ~pick);
    assign advance = job_valid && (!out_valid_reg || out_ready);
    assign job_pop = advance && !more;

    always_comb begin
        piece = job.outer;
        if (pick[rso_pkg::PIECE_RIGHT]) begin
            piece = '{x0: job.inner.x1, y0: job.inner.y0, x1: job.outer.x1, y1: job.inner.y1};
        end else if (pick[rso_pkg::PIECE_LEFT]) begin
            piece = '{x0: job.outer.x0, y0: job.inner.y0, x1: job.inner.x0, y1: job.inner.y1};
        end else if (pick[rso_pkg::PIECE_BOTTOM]) begin
            piece = '{x0: job.outer.x0, y0: job.inner.y1, x1: job.outer.x1, y1: job.outer.y1};
        end else if (pick[rso_pkg::PIECE_TOP]) begin
            piece = '{x0: job.outer.x0, y0: job.outer.y0, x1: job.outer.x1, y1: job.inner.y0};
        end

        piece_w = rso_pkg::size_t'(piece.x1) - rso_pkg::size_t'(piece.x0);
        piece_h = rso_pkg::size_t'(piece.y1) - rso_pkg::size_t'(piece.y0);

        out_data_next = '0;
        if (|job.mask) begin
            out_data_next[0 +: EB]           = piece.x0;
            out_data_next[EB +: EB]          = piece.y0;
            out_data_next[2*EB +: SB]        = piece_w;
            out_data_next[2*EB + SB +: SB]   = piece_h;
        end

        done_next = done_reg;
        if (advance) begin
            done_next = more ? (done_reg | pick) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end else begin
            done_reg <= done_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg    <= out_data_next;
            out_present_reg <= |job.mask;
            out_last_reg    <= !more;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign out_present = out_present_reg;
    assign out_last    = out_last_reg;

endmodule

@@ design/rect_set_ops.sv @@
`timescale 1ns / 1ps

// Set operations on two axis-aligned rectangles (intersect, union, A minus B,
// merge). Each input transfer gives a command and rectangles A and B; it yields
// one to four output transfers, the final one marked by m_axis_tlast: one for
// intersect, union and merge, up to four for a difference. The output stage
// issues one rectangle per cycle unless m_axis_tready holds it back. A
// three-stage front end classifies each input into a job and parks it in a
// two-entry queue, so inputs keep flowing while the output side drains or
// stalls, until the queue and the front end fill up.
// m_axis_tuser flags whether the transfer carries a rectangle; an empty
// difference or a failed merge gives one transfer with the flag low and zeros.

module rect_set_ops (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height (16 bits each)
    input  logic [rso_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // cmd
    input  logic [1:0]                          s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x (17), out_y (17), out_width (18), out_height (18), zero fill
    output logic [rso_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // present
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    logic           fr_valid, fr_ready;
    rso_pkg::job_t  fr_job;
    logic           q_valid, q_pop;
    rso_pkg::job_t  q_job;

    rso_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (rso_pkg::cmd_t'(s_axis_tuser)),
        .in_data   (s_axis_tdata),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    rso_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_job   (fr_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_job    (q_job)
    );

    rso_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_valid),
        .job_pop     (q_pop),
        .job         (q_job),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_present (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

    // an empty result always stands alone
    a_absent_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result not marked last");

    a_absent_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty result carries nonzero rectangle");

    // only difference pieces come in runs, and those are never empty
    a_run_is_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("non-final result without a rectangle");

endmodule

@@ tb/sv/rect_set_ops_test.sv @@
`timescale 1ns / 1ps

module rect_set_ops_test;

    localparam int EDGE_BITS   = rso_pkg::EDGE_BITS;
    localparam int SIZE_BITS   = rso_pkg::SIZE_BITS;
    localparam int X_LO        = 0;
    localparam int Y_LO        = EDGE_BITS;
    localparam int W_LO        = 2 * EDGE_BITS;
    localparam int H_LO        = 2 * EDGE_BITS + SIZE_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 90;

    // one rectangle at full precision, so edges never wrap
    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] w;
        logic signed [63:0] h;
    } rect_t;

    typedef struct packed {
        rso_pkg::cmd_t   cmd;
        rso_pkg::coord_t ax;
        rso_pkg::coord_t ay;
        rso_pkg::coord_t aw;
        rso_pkg::coord_t ah;
        rso_pkg::coord_t bx;
        rso_pkg::coord_t by;
        rso_pkg::coord_t bw;
        rso_pkg::coord_t bh;
        logic            quick;
        logic            drain_first;
        logic            flood;
    } rect_job_t;

    typedef struct packed {
        logic            present;
        rso_pkg::edge_t  x;
        rso_pkg::edge_t  y;
        rso_pkg::size_t  w;
        rso_pkg::size_t  h;
        logic            last;
    } rect_out_t;

    logic                               aclk;
    logic                               aresetn = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [rso_pkg::IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic [1:0]                         s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [rso_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               m_axis_tlast;

    rect_job_t rect_jobs[$];
    rect_out_t pending_rects[$];
    rect_job_t cur_job;
    rect_out_t want;
    rso_pkg::edge_t got_x;
    rso_pkg::edge_t got_y;
    rso_pkg::size_t got_w;
    rso_pkg::size_t got_h;

    int  n_queued = 0;
    int  n_sent = 0;
    int  n_results = 0;
    int  n_absent = 0;
    int  n_errors = 0;
    int  cmd_seen[4] = '{0, 0, 0, 0};
    int  send_gap = 0;
    int  rx_wait = 0;
    bit  rx_calm = 1'b0;
    bit  long_done = 1'b0;
    logic flood_on = 1'b0;
    int  cycles = 0;

    rect_set_ops u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_rects.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- geometry ----------------

    function automatic longint pick_max(longint p, longint q);
        return (p > q) ? p : q;
    endfunction

    function automatic longint pick_min(longint p, longint q);
        return (p < q) ? p : q;
    endfunction

    function automatic rect_t make_rect(longint x, longint y, longint w, longint h);
        rect_t r;
        r.x = x;
        r.y = y;
        r.w = w;
        r.h = h;
        return r;
    endfunction

    function automatic bit is_void(rect_t r);
        return (r.w <= 0) || (r.h <= 0);
    endfunction

    function automatic rect_t overlap_of(rect_t a, rect_t b);
        longint x0, y0, x1, y1;
        x0 = pick_max(a.x, b.x);
        y0 = pick_max(a.y, b.y);
        x1 = pick_min(a.x + a.w, b.x + b.w);
        y1 = pick_min(a.y + a.h, b.y + b.h);
        return make_rect(x0, y0, x1 - x0, y1 - y0);
    endfunction

    function automatic rect_t bound_of(rect_t a, rect_t b);
        longint x0, y0, x1, y1;
        if (is_void(a))
            return b;
        if (is_void(b))
            return a;
        x0 = pick_min(a.x, b.x);
        y0 = pick_min(a.y, b.y);
        x1 = pick_max(a.x + a.w, b.x + b.w);
        y1 = pick_max(a.y + a.h, b.y + b.h);
        return make_rect(x0, y0, x1 - x0, y1 - y0);
    endfunction

    // A minus B, pieces in right, left, bottom, top order
    function automatic int carve(rect_t a, rect_t b, output rect_t [3:0] pcs);
        rect_t       i;
        rect_t [3:0] cand;
        int          n;
        int          k;
        pcs = '0;
        n = 0;
        i = overlap_of(a, b);
        if (is_void(i)) begin
            pcs[0] = a;
            return 1;
        end
        cand[0] = make_rect(i.x + i.w, i.y, (a.x + a.w) - (i.x + i.w), i.h);
        cand[1] = make_rect(a.x, i.y, i.x - a.x, i.h);
        cand[2] = make_rect(a.x, i.y + i.h, a.w, (a.y + a.h) - (i.y + i.h));
        cand[3] = make_rect(a.x, a.y, a.w, i.y - a.y);
        for (k = 0; k < 4; k++) begin
            if (!is_void(cand[k])) begin
                pcs[n] = cand[k];
                n++;
            end
        end
        return n;
    endfunction

    function automatic void push_rect(bit present, rect_t r, bit last);
        rect_out_t o;
        if (!present)
            r = '0;
        o.present = present;
        o.x       = r.x[EDGE_BITS-1:0];
        o.y       = r.y[EDGE_BITS-1:0];
        o.w       = r.w[SIZE_BITS-1:0];
        o.h       = r.h[SIZE_BITS-1:0];
        o.last    = last;
        pending_rects.push_back(o);
    endfunction

    function automatic void predict_rects(rect_job_t j);
        rect_t       a, b, u;
        rect_t [3:0] pcs;
        rect_t [3:0] rest;
        int          n;
        int          k;
        a = make_rect(j.ax, j.ay, j.aw, j.ah);
        b = make_rect(j.bx, j.by, j.bw, j.bh);
        case (j.cmd)
            rso_pkg::CMD_INTERSECT: begin
                push_rect(1'b1, overlap_of(a, b), 1'b1);
            end
            rso_pkg::CMD_UNION: begin
                push_rect(1'b1, bound_of(a, b), 1'b1);
            end
            rso_pkg::CMD_DIFFERENCE: begin
                n = carve(a, b, pcs);
                if (n == 0)
                    push_rect(1'b0, a, 1'b1);
                else
                    for (k = 0; k < n; k++)
                        push_rect(1'b1, pcs[k], k == n - 1);
            end
            default: begin
                u = bound_of(a, b);
                if (!is_void(overlap_of(a, b)) || is_void(u)) begin
                    push_rect(1'b0, u, 1'b1);
                end else begin
                    n = carve(u, a, pcs);
                    if (n > 1 || (n == 1 && carve(pcs[0], b, rest) != 0))
                        push_rect(1'b0, u, 1'b1);
                    else
                        push_rect(1'b1, u, 1'b1);
                end
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic rect_job_t mk_job(rso_pkg::cmd_t cmd, int ax, int ay, int aw, int ah,
                                         int bx, int by, int bw, int bh);
        rect_job_t j;
        j = '0;
        j.cmd = cmd;
        j.ax = rso_pkg::coord_t'(ax);
        j.ay = rso_pkg::coord_t'(ay);
        j.aw = rso_pkg::coord_t'(aw);
        j.ah = rso_pkg::coord_t'(ah);
        j.bx = rso_pkg::coord_t'(bx);
        j.by = rso_pkg::coord_t'(by);
        j.bw = rso_pkg::coord_t'(bw);
        j.bh = rso_pkg::coord_t'(bh);
        return j;
    endfunction

    function automatic rso_pkg::coord_t rnd_near(int span);
        return rso_pkg::coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic rso_pkg::coord_t rnd_size(int span);
        return rso_pkg::coord_t'($urandom_range(0, span) - span / 8);
    endfunction

    function automatic rect_job_t rand_job(bit flood);
        rect_job_t j;
        int        kind;
        int        span;
        int        jit;
        j = '0;
        j.cmd = flood ? rso_pkg::CMD_DIFFERENCE : rso_pkg::cmd_t'(2'($urandom_range(0, 3)));
        kind = $urandom_range(0, 9);
        if (kind == 0 && !flood) begin
            // raw noise over every bit
            {j.ax, j.ay, j.aw, j.ah} = {$urandom, $urandom};
            {j.bx, j.by, j.bw, j.bh} = {$urandom, $urandom};
            return j;
        end
        span = (kind == 1) ? 30000 : 40;
        j.ax = rnd_near(span);
        j.ay = rnd_near(span);
        j.aw = rnd_size(span);
        j.ah = rnd_size(span);
        jit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
        if (flood || (kind >= 5 && j.cmd == rso_pkg::CMD_DIFFERENCE)) begin
            // B inside A, so most cuts give four pieces
            j.aw = rso_pkg::coord_t'($urandom_range(12, 40));
            j.ah = rso_pkg::coord_t'($urandom_range(12, 40));
            j.bx = j.ax + rso_pkg::coord_t'($urandom_range(0, 3));
            j.by = j.ay + rso_pkg::coord_t'($urandom_range(0, 3));
            j.bw = rso_pkg::coord_t'($urandom_range(1, 8));
            j.bh = rso_pkg::coord_t'($urandom_range(1, 8));
        end else if (kind >= 5 && j.cmd == rso_pkg::CMD_MERGE) begin
            // B against one edge of A, sometimes off by one
            if ($urandom_range(0, 1) == 0) begin
                j.bx = j.ax + j.aw + rso_pkg::coord_t'(jit);
                j.by = j.ay;
                j.bw = rnd_size(span);
                j.bh = j.ah + rso_pkg::coord_t'(($urandom_range(0, 3) == 0) ? 1 : 0);
            end else begin
                j.bx = j.ax;
                j.by = j.ay + j.ah + rso_pkg::coord_t'(jit);
                j.bw = j.aw - rso_pkg::coord_t'(($urandom_range(0, 3) == 0) ? 1 : 0);
                j.bh = rnd_size(span);
            end
        end else begin
            j.bx = j.ax + rnd_near(span / 2);
            j.by = j.ay + rnd_near(span / 2);
            j.bw = rnd_size(span);
            j.bh = rnd_size(span);
        end
        return j;
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_rects(cur_job);
                cmd_seen[cur_job.cmd]++;
                n_sent++;
                send_gap = cur_job.quick ? 0 : $urandom_range(0, 8);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered transfer
            end else if (send_gap != 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rect_jobs.size() != 0 &&
                         !(rect_jobs[0].drain_first && pending_rects.size() != 0)) begin
                cur_job = rect_jobs.pop_front();
                s_axis_tdata  <= {cur_job.bh, cur_job.bw, cur_job.by, cur_job.bx,
                                  cur_job.ah, cur_job.aw, cur_job.ay, cur_job.ax};
                s_axis_tuser  <= cur_job.cmd;
                s_axis_tvalid <= 1'b1;
                if (cur_job.flood)
                    flood_on <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(string what, longint got, longint wanted);
        if (n_errors < 40)
            $display("mismatch at result %0d: %s got %0d, wanted %0d",
                     n_results, what, got, wanted);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got_x = m_axis_tdata[X_LO +: EDGE_BITS];
                got_y = m_axis_tdata[Y_LO +: EDGE_BITS];
                got_w = m_axis_tdata[W_LO +: SIZE_BITS];
                got_h = m_axis_tdata[H_LO +: SIZE_BITS];
                if (pending_rects.size() == 0) begin
                    report_mismatch("transfer with nothing pending", got_x, 0);
                end else begin
                    want = pending_rects.pop_front();
                    if (!want.present)
                        n_absent++;
                    if (m_axis_tuser !== want.present)
                        report_mismatch("present", m_axis_tuser, want.present);
                    if (got_x !== want.x)
                        report_mismatch("out_x", got_x, want.x);
                    if (got_y !== want.y)
                        report_mismatch("out_y", got_y, want.y);
                    if (got_w !== want.w)
                        report_mismatch("out_width", got_w, want.w);
                    if (got_h !== want.h)
                        report_mismatch("out_height", got_h, want.h);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                end
                if (n_results % 24 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            end
            // back up the output once while the sender floods the input
            if (flood_on && !long_done) begin
                rx_wait   = LONG_STALL;
                long_done = 1'b1;
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        rect_job_t j;
        int        blk;
        int        k;

        rect_jobs.push_back(mk_job(rso_pkg::CMD_INTERSECT, 0, 0, 10, 10, 5, 5, 10, 10));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_INTERSECT, 0, 0, 5, 5, 20, 20, 5, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_INTERSECT, -32768, -32768, 32767, 32767,
                                   32767, 32767, 32767, 32767));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_INTERSECT, 32767, -32768, -32768, 32767,
                                   -32768, 32767, -1, -32768));
        // union with one side empty copies the other
        rect_jobs.push_back(mk_job(rso_pkg::CMD_UNION, 0, 0, 0, 5, 3, 4, 6, 7));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_UNION, 1, 2, 3, 4, 9, 9, 5, -3));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_UNION, -10, -10, 5, 5, 20, 30, 5, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_UNION, -32768, -32768, 32767, 32767,
                                   32767, 32767, 32767, 32767));
        // difference: four pieces, nothing left, disjoint, empty A, partial cuts
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 0, 0, 20, 20, 5, 5, 5, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 5, 5, 5, 5, 0, 0, 20, 20));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 0, 0, 5, 5, 10, 10, 5, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 0, 0, -4, 5, 0, 0, 10, 10));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 0, 0, 10, 10, -5, -5, 10, 20));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 0, 0, 10, 10, 5, -5, 10, 10));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, -32768, -32768, 32767, 32767,
                                   -100, -100, 200, 200));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_DIFFERENCE, 3, 3, 7, 7, 3, 3, 7, 7));
        // merge: tiles side by side and stacked, overlap, empty union,
        // L shape, empty A, diagonal, extreme edges
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 10, 5, 10, 0, 6, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 10, 5, 0, 5, 10, 3));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 10, 10, 5, 5, 10, 10));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 0, 0, 1, 1, -1, 2));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 10, 5, 10, 0, 6, 3));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 0, 5, 2, 2, 4, 4));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, 0, 0, 5, 5, 10, 10, 5, 5));
        rect_jobs.push_back(mk_job(rso_pkg::CMD_MERGE, -32768, 0, 32767, 100,
                                   -1, 0, 32767, 100));

        // block 2 runs without gaps, block 4 floods against a stalled output
        for (blk = 0; blk < 8; blk++) begin
            for (k = 0; k < 31; k++) begin
                j = rand_job(blk == 4);
                j.quick = (blk == 2 || blk == 4);
                j.flood = (blk == 4);
                j.drain_first = (k == 0 && (blk == 0 || blk == 5));
                rect_jobs.push_back(j);
            end
        end
        n_queued = rect_jobs.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_sent != n_queued)
            @(posedge aclk);
        while (pending_rects.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d transfers: %0d intersect, %0d union, %0d difference, %0d merge",
                 n_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("checked %0d results (%0d without a rectangle), %0d mismatches",
                 n_results, n_absent, n_errors);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
